### src/dhd_pkg.sv
`default_nettype none

package dhd_pkg;

  // Default depth of the command queue between front and back.
  localparam int unsigned QueueDepthDef = 4;

  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;

  // Stream phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_START  = 3'b010,
    PH_DIFFS  = 3'b100
  } phase_t;

  // Work for the back part: one start value or one or two differences.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             is_start;
    logic             two;
    logic             last0;
    logic             last1;
  } cmd_t;

endpackage

`default_nettype wire

### src/dhd_front.sv
`default_nettype none

module dhd_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [dhd_pkg::WordW-1:0]  in_word,
  input  wire logic                       in_last,
  output logic                            cmd_valid,
  input  wire logic                       cmd_ready,
  output dhd_pkg::cmd_t                   cmd
);

  dhd_pkg::phase_t            phase, phase_next;
  logic [dhd_pkg::WordW-1:0]  remaining, remaining_next;
  logic                       push_req;
  logic                       accept;
  logic                       rem_zero, rem_one, rem_two;

  assign rem_zero = (remaining == '0);
  assign rem_one  = (remaining == dhd_pkg::WordW'(1));
  assign rem_two  = (remaining == dhd_pkg::WordW'(2));

  // Hold words while the queue is full, even those that yield nothing.
  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = in_valid && push_req;

  always_comb begin
    push_req       = 1'b0;
    phase_next     = phase;
    remaining_next = remaining;
    cmd.word       = in_word;
    cmd.is_start   = 1'b0;
    cmd.two        = 1'b0;
    cmd.last0      = 1'b0;
    cmd.last1      = 1'b0;
    case (phase)
      dhd_pkg::PH_START: begin
        push_req     = 1'b1;
        cmd.is_start = 1'b1;
        cmd.last0    = rem_zero || in_last;
        phase_next   = in_last ? dhd_pkg::PH_HEADER : dhd_pkg::PH_DIFFS;
      end
      dhd_pkg::PH_DIFFS: begin
        // With one difference left the first sample is also the final one;
        // with two, only the second can close the stream.
        push_req   = !rem_zero;
        cmd.two    = !rem_one;
        cmd.last0  = rem_one;
        cmd.last1  = rem_two || in_last;
        if (rem_zero || rem_one) begin
          remaining_next = '0;
        end else begin
          remaining_next = remaining - dhd_pkg::WordW'(2);
        end
        phase_next = in_last ? dhd_pkg::PH_HEADER : dhd_pkg::PH_DIFFS;
      end
      default: begin
        // Header word: count of zero or one leaves only the start value.
        if (in_word > dhd_pkg::WordW'(1)) begin
          remaining_next = in_word - dhd_pkg::WordW'(1);
        end else begin
          remaining_next = '0;
        end
        phase_next = in_last ? dhd_pkg::PH_HEADER : dhd_pkg::PH_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= dhd_pkg::PH_HEADER;
      remaining <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end

endmodule

`default_nettype wire

### src/dhd_queue.sv
`default_nettype none

module dhd_queue #(
  parameter int unsigned Depth = dhd_pkg::QueueDepthDef
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dhd_pkg::cmd_t  in_cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dhd_pkg::cmd_t       out_cmd
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dhd_pkg::cmd_t   entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign in_ready  = (count != CntW'(Depth));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue fill beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers differ while empty");
`endif

endmodule

`default_nettype wire

### src/dhd_back.sv
`default_nettype none

module dhd_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  wire dhd_pkg::cmd_t                    cmd,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [dhd_pkg::WordW-1:0]      out_sample,
  output logic                                  out_last
);

  logic [dhd_pkg::WordW-1:0] running;
  logic [dhd_pkg::WordW-1:0] value;
  logic [dhd_pkg::HalfW-1:0] half;
  logic                      idx;
  logic                      load;
  logic                      done;

  assign half = idx ? cmd.word[dhd_pkg::WordW-1:dhd_pkg::HalfW]
                    : cmd.word[dhd_pkg::HalfW-1:0];
  assign value = cmd.is_start ? cmd.word
               : running + {{(dhd_pkg::WordW-dhd_pkg::HalfW){half[dhd_pkg::HalfW-1]}}, half};

  // Advance whenever the output register is free or being drained.
  assign load      = cmd_valid && (!out_valid || out_ready);
  assign done      = cmd.is_start || !cmd.two || idx;
  assign cmd_ready = load && done;

  always_ff @(posedge clk) begin
    if (load) begin
      out_sample <= value;
      out_last   <= idx ? cmd.last1 : cmd.last0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      running   <= '0;
      idx       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        running   <= value;
        idx       <= !done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_pair: assert property (@(posedge clk) disable iff (rst)
    idx |-> (cmd_valid && cmd.two && !cmd.is_start))
    else $error("second difference pending without a pair command");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (load && !idx && !cmd.is_start && cmd.two) |=> idx)
    else $error("second difference skipped");

  a_pop_done: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |=> !idx)
    else $error("command released with a difference still pending");
`endif

endmodule

`default_nettype wire

### src/delta_halfword_decoder.sv
`default_nettype none

// Delta decoder for a stream of 32-bit words: a header count, a start value
// (emitted at once), then words of two signed 16-bit differences, low half
// first, each added with 32-bit wrap to a running value and the sum emitted,
// until count samples in all have gone out. A count of zero or one gives only
// the start value. The request marked tlast ends the stream and returns the
// block to the header state; the final sample it yields carries tlast.
// The front part takes one request per cycle while the queue has room, tracks
// phase and remaining count, and queues work for the back part, which adds
// and emits exactly one sample per cycle through a registered output while
// m_tready does not stall it. A difference word with two samples therefore
// holds the back part until both samples are out; header words and exhausted
// words queue no work. A sample passes through a queue entry and then the
// output register after its request is accepted. QUEUE_DEPTH sets how many
// queued words absorb stalls on the output side before s_tready drops.
module delta_halfword_decoder #(
  parameter int unsigned QUEUE_DEPTH = dhd_pkg::QueueDepthDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [dhd_pkg::WordW-1:0]      s_tdata,   // [31:0] word
  input  wire logic                           s_tlast,   // last_word
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic signed [dhd_pkg::WordW-1:0]    m_tdata,   // [31:0] sample
  output logic                                m_tlast    // last_sample
);

  logic          f_valid, f_ready;
  dhd_pkg::cmd_t f_cmd;
  logic          q_valid, q_ready;
  dhd_pkg::cmd_t q_cmd;

  // Classify requests and keep the stream phase and count.
  dhd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_word   (s_tdata),
    .in_last   (s_tlast),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // Decouple the two halves so each may stall on its own.
  dhd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  // Accumulate and emit samples, one per cycle while m_tready allows.
  dhd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

`default_nettype wire
